>>> design/pba_pkg.sv
`default_nettype none
package pba_pkg;
    localparam int MaxPools = 4;
    localparam int IdxW = 2;
    localparam int CntW = 3;
    localparam logic [31:0] HeaderBytes = 32'd24;
    localparam logic [31:0] MinPoolBytes = 32'h34;
    localparam logic [31:0] BestInit = 32'h7fffffff;
    localparam logic [15:0] SetupMode = 16'h0ff8;

    localparam logic [2:0] KIND_ADD = 3'd0;
    localparam logic [2:0] KIND_FINISH = 3'd1;
    localparam logic [2:0] KIND_ALLOC = 3'd2;
    localparam logic [2:0] KIND_BIG_LO = 3'd3;
    localparam logic [2:0] KIND_BIG_HI = 3'd4;
    localparam logic [2:0] KIND_FREE_LO = 3'd5;
    localparam logic [2:0] KIND_FREE_HI = 3'd6;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_OOM = 2'd1;
    localparam logic [1:0] ST_NOPOOL = 2'd2;
    localparam logic [1:0] ST_SMALL = 2'd3;

    typedef enum logic [1:0] {
        SCAN_FIT = 2'd0,
        SCAN_BIG = 2'd1,
        SCAN_SECOND = 2'd2
    } scan_mode_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        scan_mode_t mode;
        logic execute;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic [2:0] kind;
    } stat_t;
endpackage
`default_nettype wire

>>> design/pba_ctrl.sv
`default_nettype none
module pba_ctrl (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input wire logic out_ready,
    input wire pba_pkg::stat_t stat,
    output pba_pkg::cmd_t cmd
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN1 = 6'b000010,
        S_SCAN2 = 6'b000100,
        S_EXEC = 6'b001000,
        S_OUT = 6'b010000,
        S_SCANF = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.mode = pba_pkg::SCAN_FIT;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (stat.kind == pba_pkg::KIND_FINISH)
                    begin
                        state_next = S_SCAN1;
                    end
                    else if (stat.kind == pba_pkg::KIND_ALLOC)
                    begin
                        state_next = S_SCANF;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_SCANF:
            begin
                cmd.mode = pba_pkg::SCAN_FIT;
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_EXEC;
                end
            end
            S_SCAN1:
            begin
                cmd.mode = pba_pkg::SCAN_BIG;
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    cmd.scan_start = 1'b1;
                    state_next = S_SCAN2;
                end
            end
            S_SCAN2:
            begin
                cmd.mode = pba_pkg::SCAN_SECOND;
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> design/pba_dp.sv
`default_nettype none
module pba_dp (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic [2:0] kind,
    input wire logic [31:0] base_address,
    input wire logic [30:0] amount,
    input wire logic [15:0] mask,
    input wire pba_pkg::cmd_t cmd,
    output pba_pkg::stat_t stat,
    output logic [31:0] address,
    output logic [1:0] status
);
    localparam int N = pba_pkg::MaxPools;

    logic [31:0] r_end_reg [N];
    logic [31:0] r_free_reg [N];
    logic [31:0] r_size_reg [N];
    logic [15:0] r_mode_reg [N];
    logic [N-1:0] r_tag_reg;
    logic [pba_pkg::CntW-1:0] count_reg;
    logic [31:0] big_end_reg, big_free_reg, sec_end_reg, sec_free_reg;
    logic [15:0] sec_mode_reg;

    logic [2:0] kind_reg;
    logic [31:0] base_reg, req_reg, size_reg;
    logic [15:0] mask_reg;

    logic [pba_pkg::CntW-1:0] ptr_reg;
    logic [31:0] best_reg;
    logic b_found_reg, s_found_reg, p_found_reg;
    logic [pba_pkg::IdxW-1:0] b_idx_reg, s_idx_reg, p_idx_reg;

    logic [31:0] addr_reg;
    logic [1:0] status_reg;

    logic [pba_pkg::IdxW-1:0] cur;
    logic cur_valid;
    logic [31:0] left;
    logic setup_ok, fit_ok, big_take;

    assign cur = ptr_reg[pba_pkg::IdxW-1:0] - 1'b1;
    assign cur_valid = (ptr_reg != '0);
    assign left = r_free_reg[cur] - req_reg;
    assign setup_ok = cur_valid && !r_tag_reg[cur]
        && ((r_mode_reg[cur] & pba_pkg::SetupMode) == pba_pkg::SetupMode)
        && !(cmd.mode == pba_pkg::SCAN_SECOND && b_found_reg && b_idx_reg == cur)
        && (r_size_reg[cur] > best_reg);
    assign fit_ok = cur_valid && !r_tag_reg[cur]
        && ((r_mode_reg[cur] & mask_reg) == mask_reg)
        && (r_free_reg[cur] >= req_reg) && (left < best_reg);
    assign stat.scan_last = (ptr_reg <= {{(pba_pkg::CntW-1){1'b0}}, 1'b1});
    assign stat.kind = kind;
    assign address = addr_reg;
    assign status = status_reg;
    assign big_take = (req_reg <= big_free_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            base_reg <= base_address;
            req_reg <= {1'b0, amount} + {31'd0, amount[0]};
            size_reg <= {1'b0, amount[30:1], 1'b0};
            mask_reg <= mask;
            ptr_reg <= count_reg;
            best_reg <= (kind == pba_pkg::KIND_ALLOC) ? pba_pkg::BestInit : 32'd0;
            b_found_reg <= 1'b0;
            s_found_reg <= 1'b0;
            p_found_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            ptr_reg <= count_reg;
            best_reg <= 32'd0;
            if (setup_ok)
            begin
                b_found_reg <= 1'b1;
                b_idx_reg <= cur;
            end
        end
        else if (cmd.scan_step)
        begin
            ptr_reg <= ptr_reg - 1'b1;
            case (cmd.mode)
                pba_pkg::SCAN_FIT:
                begin
                    if (fit_ok)
                    begin
                        best_reg <= left;
                        p_found_reg <= 1'b1;
                        p_idx_reg <= cur;
                    end
                end
                pba_pkg::SCAN_BIG:
                begin
                    if (setup_ok)
                    begin
                        best_reg <= r_size_reg[cur];
                        b_found_reg <= 1'b1;
                        b_idx_reg <= cur;
                    end
                end
                pba_pkg::SCAN_SECOND:
                begin
                    if (setup_ok)
                    begin
                        best_reg <= r_size_reg[cur];
                        s_found_reg <= 1'b1;
                        s_idx_reg <= cur;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                r_end_reg[i] <= '0;
                r_free_reg[i] <= '0;
                r_size_reg[i] <= '0;
                r_mode_reg[i] <= '0;
            end
            r_tag_reg <= '0;
            count_reg <= '0;
            big_end_reg <= '0;
            big_free_reg <= '0;
            sec_end_reg <= '0;
            sec_free_reg <= '0;
            sec_mode_reg <= '0;
            addr_reg <= '0;
            status_reg <= pba_pkg::ST_OK;
        end
        else if (cmd.execute)
        begin
            addr_reg <= '0;
            status_reg <= pba_pkg::ST_OK;
            case (kind_reg)
                pba_pkg::KIND_ADD:
                begin
                    if (size_reg < pba_pkg::MinPoolBytes
                        || count_reg >= pba_pkg::CntW'(N))
                    begin
                        status_reg <= pba_pkg::ST_SMALL;
                    end
                    else
                    begin
                        r_end_reg[count_reg[pba_pkg::IdxW-1:0]] <= base_reg + size_reg;
                        r_size_reg[count_reg[pba_pkg::IdxW-1:0]] <=
                            size_reg - pba_pkg::HeaderBytes;
                        r_free_reg[count_reg[pba_pkg::IdxW-1:0]] <=
                            size_reg - pba_pkg::HeaderBytes;
                        r_mode_reg[count_reg[pba_pkg::IdxW-1:0]] <= mask_reg;
                        r_tag_reg[count_reg[pba_pkg::IdxW-1:0]] <= 1'b0;
                        count_reg <= count_reg + 1'b1;
                    end
                end
                pba_pkg::KIND_FINISH:
                begin
                    if (!b_found_reg)
                    begin
                        status_reg <= pba_pkg::ST_NOPOOL;
                    end
                    else
                    begin
                        r_tag_reg[b_idx_reg] <= 1'b1;
                        big_end_reg <= r_end_reg[b_idx_reg];
                        big_free_reg <= r_size_reg[b_idx_reg];
                        if (s_found_reg)
                        begin
                            r_tag_reg[s_idx_reg] <= 1'b1;
                            sec_mode_reg <= r_mode_reg[s_idx_reg];
                            sec_end_reg <= r_end_reg[s_idx_reg] + r_size_reg[s_idx_reg]
                                - r_free_reg[s_idx_reg];
                            sec_free_reg <= r_size_reg[s_idx_reg];
                        end
                    end
                end
                pba_pkg::KIND_ALLOC, pba_pkg::KIND_BIG_LO, pba_pkg::KIND_BIG_HI:
                begin
                    if (kind_reg == pba_pkg::KIND_ALLOC && p_found_reg)
                    begin
                        r_free_reg[p_idx_reg] <= r_free_reg[p_idx_reg] - req_reg;
                        r_end_reg[p_idx_reg] <= r_end_reg[p_idx_reg] - req_reg;
                        addr_reg <= r_end_reg[p_idx_reg] - req_reg;
                    end
                    else if (kind_reg == pba_pkg::KIND_ALLOC
                        && (sec_mode_reg & mask_reg) == mask_reg
                        && req_reg <= sec_free_reg)
                    begin
                        sec_free_reg <= sec_free_reg - req_reg;
                        sec_end_reg <= sec_end_reg - req_reg;
                        addr_reg <= sec_end_reg - req_reg;
                    end
                    else if (!big_take)
                    begin
                        status_reg <= pba_pkg::ST_OOM;
                    end
                    else
                    begin
                        if (kind_reg == pba_pkg::KIND_BIG_HI)
                        begin
                            addr_reg <= big_end_reg - big_free_reg;
                        end
                        else
                        begin
                            big_end_reg <= big_end_reg - req_reg;
                            addr_reg <= big_end_reg - req_reg;
                        end
                        big_free_reg <= big_free_reg - req_reg;
                    end
                end
                pba_pkg::KIND_FREE_LO:
                begin
                    big_free_reg <= big_free_reg + req_reg;
                    big_end_reg <= big_end_reg + req_reg;
                end
                pba_pkg::KIND_FREE_HI:
                begin
                    big_free_reg <= big_free_reg + req_reg;
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

>>> design/pool_bump_allocator_top.sv
// Pool allocator over four regions that serves one request at a time. Add, free and big-pool
// requests pass from acceptance through an execute state to a result state, and the block
// takes no new request until the result is taken; pool allocation first runs one pool scan and
// finish setup two, one entry per cycle, and each scan runs even when no pool exists.
`default_nettype none
module pool_bump_allocator_top (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_ready,
    input wire logic [2:0] kind,
    input wire logic [31:0] base_address,
    input wire logic [30:0] amount,
    input wire logic [15:0] mask,
    output logic out_valid,
    input wire logic out_ready,
    output logic [31:0] address,
    output logic [1:0] status
);
    pba_pkg::cmd_t cmd;
    pba_pkg::stat_t stat;

    pba_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
    );

    pba_dp u_dp (
        .clk(clk), .rst_n(rst_n), .kind(kind), .base_address(base_address),
        .amount(amount), .mask(mask), .cmd(cmd), .stat(stat),
        .address(address), .status(status)
    );

    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("ready while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(address))
        else $error("result changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid)
        else $error("result too early");
endmodule
`default_nettype wire
